>>> design/ita_pkg.sv
`default_nettype none
package ita_pkg;

	// operand and field limits
	localparam int VALUE_BITS = 64;
	localparam int MAX_WIDTH  = 64;
	localparam int WIDTH_W    = 7;

	// digit store: enough lanes for 22 octal digits of a 64-bit word
	localparam int DIG_N  = 24;
	localparam int DIG_IW = $clog2(DIG_N);

	// binary to bcd conversion: one bit per cycle
	localparam int CONV_STEPS = 64;
	localparam int CONV_CW    = $clog2(CONV_STEPS);

	localparam logic [63:0] VAL_MASK = {64{1'b1}} >> (64 - VALUE_BITS);

	// ascii codes
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_A     = 8'h61;

	// radix codes, the unused code formats as hex
	typedef enum logic [1:0] {
		RADIX_OCT = 2'd0,
		RADIX_DEC = 2'd1,
		RADIX_HEX = 2'd2
	} radix_t;

	// control from the sequencer to the digit unit
	typedef struct packed {
		logic              load;
		logic [1:0]        radix;
		logic [DIG_IW-1:0] rd_idx;
	} dig_ctl_t;

	// status from the digit unit
	typedef struct packed {
		logic       busy;
		logic [3:0] digit;
	} dig_stat_t;

	// lowercase digit character
	function automatic logic [7:0] digit_char(input logic [3:0] d);
		if (d < 4'd10) begin
			digit_char = CH_ZERO + {4'd0, d};
		end else begin
			digit_char = CH_A + {4'd0, d} - 8'd10;
		end
	endfunction

endpackage
`default_nettype wire

>>> design/ita_digits.sv
`default_nettype none
module ita_digits import ita_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire dig_ctl_t    ctl,
	input  wire logic [63:0] mag,
	output dig_stat_t        stat
);

	logic [3:0]         dig_q [DIG_N];
	logic [3:0]         adj   [DIG_N];
	logic [3:0]         dab   [DIG_N];
	logic [3:0]         ld    [DIG_N];
	logic [63:0]        sh_q;
	logic [CONV_CW-1:0] cnt_q;
	logic               busy_q;
	logic [65:0]        mag_x;

	assign mag_x = {2'b00, mag};

	// load pattern for each radix
	always_comb begin
		for (int i = 0; i < DIG_N; i++) begin
			ld[i] = 4'd0;
		end
		case (ctl.radix)
			RADIX_OCT: begin
				for (int i = 0; i < 22; i++) begin
					ld[i] = {1'b0, mag_x[3*i +: 3]};
				end
			end
			RADIX_DEC: begin
				for (int i = 0; i < DIG_N; i++) begin
					ld[i] = 4'd0;
				end
			end
			default: begin
				for (int i = 0; i < 16; i++) begin
					ld[i] = mag[4*i +: 4];
				end
			end
		endcase
	end

	// shift-add-3 step over all bcd lanes
	always_comb begin
		for (int i = 0; i < DIG_N; i++) begin
			adj[i] = (dig_q[i] >= 4'd5) ? dig_q[i] + 4'd3 : dig_q[i];
		end
		dab[0] = {adj[0][2:0], sh_q[63]};
		for (int i = 1; i < DIG_N; i++) begin
			dab[i] = {adj[i][2:0], adj[i-1][3]};
		end
	end

	// conversion control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctl.load) begin
			busy_q <= (ctl.radix == RADIX_DEC);
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CONV_CW'(CONV_STEPS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// digit lanes and shift source
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			dig_q <= ld;
			sh_q  <= mag;
		end else if (busy_q) begin
			dig_q <= dab;
			sh_q  <= {sh_q[62:0], 1'b0};
		end
	end

	assign stat.busy  = busy_q;
	assign stat.digit = dig_q[ctl.rd_idx];

endmodule
`default_nettype wire

>>> design/ita_emit.sv
`default_nettype none
module ita_emit import ita_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [63:0]        value,
	input  wire logic [1:0]         radix,
	input  wire logic               signed_mode,
	input  wire logic               plus_sign,
	input  wire logic               alt_prefix,
	input  wire logic [WIDTH_W-1:0] pad_width,
	input  wire logic               in_valid,
	output logic                    in_stall,
	output logic [7:0]              character,
	output logic                    last,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output dig_ctl_t                ctl,
	output logic [63:0]             mag,
	input  wire dig_stat_t          stat
);

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_CONV = 8'b0000_0010,
		ST_SCAN = 8'b0000_0100,
		ST_PAD  = 8'b0000_1000,
		ST_SIGN = 8'b0001_0000,
		ST_PFX0 = 8'b0010_0000,
		ST_PFXX = 8'b0100_0000,
		ST_DIG  = 8'b1000_0000
	} state_t;

	state_t             state_q;
	logic [DIG_IW-1:0]  idx_q;
	logic [WIDTH_W-1:0] width_q;
	logic [WIDTH_W-1:0] pad_q;
	logic               neg_q;
	logic               plus_q;
	logic [1:0]         pfx_q;
	logic [7:0]         char_q;
	logic               last_q;
	logic               oval_q;

	logic [63:0]        v;
	logic               neg;
	logic               accept;
	logic               can_emit;
	logic               emit;
	logic [1:0]         pfx_len;
	logic [WIDTH_W-1:0] len;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign can_emit = !oval_q || !out_stall;

	// magnitude of the request value
	assign v   = value & VAL_MASK;
	assign neg = signed_mode && v[VALUE_BITS-1];
	assign mag = neg ? ((~v + 64'd1) & VAL_MASK) : v;

	// prefix length: none for decimal or zero
	always_comb begin
		pfx_len = 2'd0;
		if (alt_prefix && (v != 64'd0)) begin
			case (radix)
				RADIX_OCT: pfx_len = 2'd1;
				RADIX_DEC: pfx_len = 2'd0;
				default:   pfx_len = 2'd2;
			endcase
		end
	end

	// field length once the top digit is found
	assign len = WIDTH_W'(idx_q) + WIDTH_W'(1) + WIDTH_W'(pfx_q) + WIDTH_W'(neg_q | plus_q);

	assign ctl.load   = accept;
	assign ctl.radix  = radix;
	assign ctl.rd_idx = idx_q;

	// a character is loaded into the output register this cycle
	always_comb begin
		case (state_q)
			ST_PAD:  emit = can_emit && (pad_q != '0);
			ST_SIGN: emit = can_emit && (neg_q || plus_q);
			ST_PFX0: emit = can_emit && (pfx_q != 2'd0);
			ST_PFXX: emit = can_emit;
			ST_DIG:  emit = can_emit;
			default: emit = 1'b0;
		endcase
	end

	// output valid: set on a new character, cleared once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oval_q <= 1'b0;
		end else if (emit) begin
			oval_q <= 1'b1;
		end else if (!out_stall) begin
			oval_q <= 1'b0;
		end
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			width_q <= '0;
			pad_q   <= '0;
			neg_q   <= 1'b0;
			plus_q  <= 1'b0;
			pfx_q   <= 2'd0;
			char_q  <= 8'd0;
			last_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						neg_q   <= neg;
						plus_q  <= signed_mode && plus_sign && !neg;
						pfx_q   <= pfx_len;
						width_q <= (pad_width > WIDTH_W'(MAX_WIDTH)) ?
							WIDTH_W'(MAX_WIDTH) : pad_width;
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					if (!stat.busy) begin
						idx_q   <= DIG_IW'(DIG_N - 1);
						state_q <= ST_SCAN;
					end
				end
				// walk down to the most significant nonzero digit
				ST_SCAN: begin
					if ((stat.digit == 4'd0) && (idx_q != '0)) begin
						idx_q <= idx_q - 1'b1;
					end else begin
						pad_q   <= (width_q > len) ? width_q - len : '0;
						state_q <= ST_PAD;
					end
				end
				ST_PAD: begin
					if (pad_q == '0) begin
						state_q <= ST_SIGN;
					end else if (can_emit) begin
						char_q <= CH_SPACE;
						last_q <= 1'b0;
						pad_q  <= pad_q - 1'b1;
					end
				end
				ST_SIGN: begin
					if (!(neg_q || plus_q)) begin
						state_q <= ST_PFX0;
					end else if (can_emit) begin
						char_q  <= neg_q ? CH_MINUS : CH_PLUS;
						last_q  <= 1'b0;
						state_q <= ST_PFX0;
					end
				end
				ST_PFX0: begin
					if (pfx_q == 2'd0) begin
						state_q <= ST_DIG;
					end else if (can_emit) begin
						char_q  <= CH_ZERO;
						last_q  <= 1'b0;
						state_q <= (pfx_q == 2'd2) ? ST_PFXX : ST_DIG;
					end
				end
				ST_PFXX: begin
					if (can_emit) begin
						char_q  <= CH_X;
						last_q  <= 1'b0;
						state_q <= ST_DIG;
					end
				end
				ST_DIG: begin
					if (can_emit) begin
						char_q <= digit_char(stat.digit);
						last_q <= (idx_q == '0);
						if (idx_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q - 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign character = char_q;
	assign last      = last_q;
	assign out_valid = oval_q;

endmodule
`default_nettype wire

>>> design/integer_to_ascii_formatter.sv
// channel  | handshake            | payload
// ---------+----------------------+-----------------------------------------------
// in       | in_valid / in_stall  | value, radix, signed_mode, plus_sign,
//          |                      | alt_prefix, pad_width
// out      | out_valid / out_stall| character, last
//
// one request at a time: the request is loaded, a decimal value then runs a
// bit-serial shift-add-3 conversion, the digit scan walks down to the top nonzero
// digit, then pad, sign, prefix and digits leave at most one character per cycle,
// none while a stalled character waits, as pad ends or as a sign or prefix is skipped.
// arst_n clears the sequencer and the output register; digit lanes are not reset.
// out_stall holds the output register and the sequencer; the last character may
// still wait in the output register while the next request is taken.
`default_nettype none
module integer_to_ascii_formatter import ita_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [63:0]        value,
	input  wire logic [1:0]         radix,
	input  wire logic               signed_mode,
	input  wire logic               plus_sign,
	input  wire logic               alt_prefix,
	input  wire logic [WIDTH_W-1:0] pad_width,
	input  wire logic               in_valid,
	output logic                    in_stall,
	output logic [7:0]              character,
	output logic                    last,
	output logic                    out_valid,
	input  wire logic               out_stall
);

	dig_ctl_t    ctl;
	dig_stat_t   stat;
	logic [63:0] mag;

	// sequencer with output register
	ita_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.value       (value),
		.radix       (radix),
		.signed_mode (signed_mode),
		.plus_sign   (plus_sign),
		.alt_prefix  (alt_prefix),
		.pad_width   (pad_width),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.character   (character),
		.last        (last),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.ctl         (ctl),
		.mag         (mag),
		.stat        (stat)
	);

	// digit store and bcd shift unit
	ita_digits u_digits (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.mag    (mag),
		.stat   (stat)
	);

endmodule
`default_nettype wire

>>> design/ita_checker.sv
`default_nettype none
module ita_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic [7:0] character,
	input wire logic       last,
	input wire logic       out_valid,
	input wire logic       out_stall
);

	// a stalled character holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(character) && $stable(last))
		else $error("stalled output changed");

	// one request at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken while busy");

	// a character waiting while idle can only be the final one
	a_idle_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !in_stall |-> last)
		else $error("idle with a non-final character pending");

	// the block frees up exactly when the final character is loaded
	a_free_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_stall) |-> out_valid && last)
		else $error("became ready without a final character");

endmodule

bind integer_to_ascii_formatter ita_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.character (character),
	.last      (last),
	.out_valid (out_valid),
	.out_stall (out_stall)
);
`default_nettype wire
